### hw/rtl/tcct_pkg.sv
// Package for the three-channel counter/timer: widths, codes, mode bit positions.
// Used by tcct_ctrl, tcct_datapath and three_channel_counter_timer.
package tcct_pkg;

   localparam int TimerCount     = 3;
   localparam int PrescaleDivide = 8;

   localparam logic [2:0] ACT_SYS_TICK  = 3'd0;
   localparam logic [2:0] ACT_EXT_TICK  = 3'd1;
   localparam logic [2:0] ACT_GATE      = 3'd2;
   localparam logic [2:0] ACT_READ      = 3'd3;
   localparam logic [2:0] ACT_WRITE     = 3'd4;

   localparam logic [3:0] REG_COUNT  = 4'h0;
   localparam logic [3:0] REG_MODE   = 4'h4;
   localparam logic [3:0] REG_TARGET = 4'h8;

   localparam int M_SYNC_EN = 0;
   localparam int M_RST_TGT = 3;
   localparam int M_IRQ_TGT = 4;
   localparam int M_IRQ_OVF = 5;
   localparam int M_REPEAT  = 6;
   localparam int M_TOGGLE  = 7;
   localparam int M_REQ_N   = 10;
   localparam int M_HIT_TGT = 11;
   localparam int M_HIT_OVF = 12;

   localparam logic [12:0] MODE_RESET = 13'h0400;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // Accept a transaction and apply it.
      logic mod_step;  // One step of the counter modulo reduction.
      logic finish;    // Load the response register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_mod;  // A reduction of a counter by its target is pending.
      logic mod_done;  // Finished reduction; the datapath ties it low, the end shows as need_mod low.
   } status_type;

endpackage

### hw/rtl/three_channel_counter_timer.sv
// Three 16-bit counter/timers behind a register bank.
// Each request transaction carries a system tick, an external tick, a gate
// change, a register read or a register write; each yields one response
// transaction with read data and a mask of timers that raised an interrupt.
// Both channels use valid and stall; a transaction moves at an edge where
// valid is high and stall is low.
// An item goes through accept and update, check, then the load of the
// response register. A counter write of at least twice a nonzero target
// with reset at target set also goes through a bit-serial divider during
// the check. One item is in flight at a time; a new request is taken only
// after the previous response is loaded. While the receiver stalls, the
// response holds and no request is taken once the block has a result ready.
// A synchronous reset clears the counters and targets, sets each mode to
// the irq request bit alone, enables counting and empties the response.
// Depends on tcct_pkg, tcct_ctrl and tcct_datapath.
module three_channel_counter_timer #(
   parameter int TIMER_COUNT     = tcct_pkg::TimerCount,
   parameter int PRESCALE_DIVIDE = tcct_pkg::PrescaleDivide
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_timer_select,
   input  logic        req_gate_level,
   input  logic [5:0]  req_register_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [2:0]  rsp_irq_raised
);

   tcct_pkg::cmd_type    cmd;
   tcct_pkg::status_type status;

   tcct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcct_datapath #(
      .TIMER_COUNT     (TIMER_COUNT),
      .PRESCALE_DIVIDE (PRESCALE_DIVIDE)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_timer_select    (req_timer_select),
      .req_gate_level      (req_gate_level),
      .req_register_offset (req_register_offset),
      .req_write_data      (req_write_data),
      .rsp_read_data       (rsp_read_data),
      .rsp_irq_raised      (rsp_irq_raised)
   );

endmodule

### hw/rtl/tcct_ctrl.sv
// Controller of the counter/timer: sequences accept, reduction and response.
// Depends on tcct_pkg.
module tcct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tcct_pkg::status_type status,
   output tcct_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MOD  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      free;

   // The response register is free when empty or being taken this cycle.
   assign free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && free);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && free) begin
               cmd.start = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (status.mod_done || !status.need_mod) begin
               state_in = ST_DONE;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_MOD)
      else $error("start did not enter reduction state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finish did not load the response");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("transaction accepted while busy");

endmodule

### hw/rtl/tcct_datapath.sv
// Datapath of the counter/timer: timer state, tick and register logic,
// restoring divider for counter writes at 2x target or more. Depends on tcct_pkg.
module tcct_datapath #(
   parameter int TIMER_COUNT     = tcct_pkg::TimerCount,
   parameter int PRESCALE_DIVIDE = tcct_pkg::PrescaleDivide
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcct_pkg::cmd_type    cmd,
   output tcct_pkg::status_type status,
   input  logic [2:0]           req_action,
   input  logic [1:0]           req_timer_select,
   input  logic                 req_gate_level,
   input  logic [5:0]           req_register_offset,
   input  logic [31:0]          req_write_data,
   output logic [31:0]          rsp_read_data,
   output logic [2:0]           rsp_irq_raised
);

   localparam int PW = $clog2(PRESCALE_DIVIDE);
   localparam logic [PW-1:0] PRE_LAST = PW'(PRESCALE_DIVIDE - 1);
   localparam int PT = 2;

   logic [15:0] cnt_ff [TIMER_COUNT];
   logic [15:0] cnt_in [TIMER_COUNT];
   logic [15:0] tgt_ff [TIMER_COUNT];
   logic [15:0] tgt_in [TIMER_COUNT];
   logic [12:0] mode_ff [TIMER_COUNT];
   logic [12:0] mode_in [TIMER_COUNT];
   logic [2:0]  gate_ff, gate_in, ext_ff, ext_in, on_ff, on_in;
   logic [2:0]  exton_ff, exton_in, done_ff, done_in;
   logic [PW-1:0] pre_ff, pre_in;
   logic [31:0] rd_ff, rd_in;
   logic [2:0]  irq_ff, irq_in;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_irq_ff;

   // Divider for a written counter value modulo target.
   logic        mod_pend_ff, mod_pend_in;
   logic [1:0]  mod_t_ff, mod_t_in;
   logic [15:0] mod_rem_ff, mod_rem_in;
   logic [15:0] mod_quo_ff, mod_quo_in;
   logic [4:0]  mod_n_ff, mod_n_in;
   logic [15:0] mod_div_ff, mod_div_in;
   logic [16:0] trial;

   typedef struct packed {
      logic [15:0] c;
      logic [12:0] m;
      logic        done;
      logic        irq;
      logic        need_mod;
      logic        ovf_after;
   } lim_type;

   function automatic lim_type irq_step(lim_type s);
      lim_type r;
      r = s;
      if (!r.m[tcct_pkg::M_REQ_N] && !(!r.m[tcct_pkg::M_REPEAT] && r.done)) begin
         r.done = 1'b1;
         r.irq  = 1'b1;
      end
      return r;
   endfunction

   // Applies the request from the limit checks.
   function automatic lim_type apply_req(lim_type s, logic req);
      lim_type r;
      r = s;
      if (req) begin
         if (!r.m[tcct_pkg::M_TOGGLE]) begin
            r.m[tcct_pkg::M_REQ_N] = 1'b0;
            r = irq_step(r);
            r.m[tcct_pkg::M_REQ_N] = 1'b1;
         end else begin
            r.m[tcct_pkg::M_REQ_N] = !r.m[tcct_pkg::M_REQ_N];
            r = irq_step(r);
         end
      end
      return r;
   endfunction

   // Limit check. c17 is the new count, possibly 0x10000 after a tick.
   function automatic lim_type check(logic [16:0] c17, logic [15:0] old,
                                     logic [15:0] tg, logic [12:0] m, logic done,
                                     logic allow_mod);
      lim_type r;
      logic    req;
      logic [16:0] c;
      r   = '0;
      r.m = m;
      r.done = done;
      req = 1'b0;
      c   = c17;
      if (c >= {1'b0, tg} && (old < tg || tg == 16'd0)) begin
         req = req || m[tcct_pkg::M_IRQ_TGT];
         r.m[tcct_pkg::M_HIT_TGT] = 1'b1;
         if (m[tcct_pkg::M_RST_TGT] && tg != 16'd0) begin
            if (c - {1'b0, tg} < {1'b0, tg}) begin
               c = c - {1'b0, tg};
            end else begin
               r.need_mod = allow_mod;
            end
         end
      end
      if (r.need_mod) begin
         // No overflow check follows the reduction; remainder < target <= 0xFFFF.
         r.ovf_after = 1'b0;
      end else if (c >= 17'h0FFFF) begin
         req = req || m[tcct_pkg::M_IRQ_OVF];
         r.m[tcct_pkg::M_HIT_OVF] = 1'b1;
         c = c - 17'h0FFFF;
      end
      r.c = c[15:0];
      r.irq = 1'b0;
      r = apply_req(r, req);
      return r;
   endfunction

   function automatic logic counting(logic [12:0] m, logic g);
      logic r;
      if (m[tcct_pkg::M_SYNC_EN]) begin
         case (m[2:1])
            2'd0:    r = !g;
            2'd1:    r = 1'b1;
            default: r = g;
         endcase
      end else begin
         r = 1'b1;
      end
      return r;
   endfunction

   assign trial = {mod_rem_ff, mod_quo_ff[15]} - {1'b0, mod_div_ff};

   always_comb begin
      lim_type     l;
      logic [1:0]  t;
      logic [3:0]  r;
      logic [15:0] nv;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         cnt_in[i]  = cnt_ff[i];
         tgt_in[i]  = tgt_ff[i];
         mode_in[i] = mode_ff[i];
      end
      gate_in  = gate_ff;
      ext_in   = ext_ff;
      on_in    = on_ff;
      exton_in = exton_ff;
      done_in  = done_ff;
      pre_in   = pre_ff;
      rd_in    = rd_ff;
      irq_in   = irq_ff;
      mod_pend_in = 1'b0;
      mod_t_in    = mod_t_ff;
      mod_rem_in  = mod_rem_ff;
      mod_quo_in  = mod_quo_ff;
      mod_n_in    = mod_n_ff;
      mod_div_in  = mod_div_ff;
      t  = req_register_offset[5:4];
      r  = req_register_offset[3:0];
      nv = req_write_data[15:0];
      l  = '0;

      if (cmd.start) begin
         rd_in  = 32'd0;
         irq_in = 3'd0;
         case (req_action)
            tcct_pkg::ACT_SYS_TICK: begin
               for (int i = 0; i < TIMER_COUNT; i++) begin
                  if (i != PT && !exton_ff[i] && on_ff[i]) begin
                     l = check({1'b0, cnt_ff[i]} + 17'd1, cnt_ff[i], tgt_ff[i],
                               mode_ff[i], done_ff[i], 1'b0);
                     cnt_in[i] = l.c; mode_in[i] = l.m; done_in[i] = l.done;
                     irq_in[i] = l.irq;
                  end
               end
               if (exton_ff[PT]) begin
                  if (pre_ff == PRE_LAST) begin
                     pre_in = '0;
                     l = check({1'b0, cnt_ff[PT]} + 17'd1, cnt_ff[PT], tgt_ff[PT],
                               mode_ff[PT], done_ff[PT], 1'b0);
                     cnt_in[PT] = l.c; mode_in[PT] = l.m; done_in[PT] = l.done;
                     irq_in[PT] = l.irq;
                  end else begin
                     pre_in = pre_ff + PW'(1);
                  end
               end else if (on_ff[PT]) begin
                  l = check({1'b0, cnt_ff[PT]} + 17'd1, cnt_ff[PT], tgt_ff[PT],
                            mode_ff[PT], done_ff[PT], 1'b0);
                  cnt_in[PT] = l.c; mode_in[PT] = l.m; done_in[PT] = l.done;
                  irq_in[PT] = l.irq;
               end
            end
            tcct_pkg::ACT_EXT_TICK: begin
               if (req_timer_select < 2'(PT) && exton_ff[req_timer_select]) begin
                  l = check({1'b0, cnt_ff[req_timer_select]} + 17'd1,
                            cnt_ff[req_timer_select], tgt_ff[req_timer_select],
                            mode_ff[req_timer_select], done_ff[req_timer_select], 1'b0);
                  cnt_in[req_timer_select]  = l.c;
                  mode_in[req_timer_select] = l.m;
                  done_in[req_timer_select] = l.done;
                  irq_in[req_timer_select]  = l.irq;
               end
            end
            tcct_pkg::ACT_GATE: begin
               if (int'(req_timer_select) < TIMER_COUNT &&
                   gate_ff[req_timer_select] != req_gate_level) begin
                  gate_in[req_timer_select] = req_gate_level;
                  if (mode_ff[req_timer_select][tcct_pkg::M_SYNC_EN]) begin
                     if (req_gate_level) begin
                        if (mode_ff[req_timer_select][2:1] == 2'd1 ||
                            mode_ff[req_timer_select][2:1] == 2'd2) begin
                           cnt_in[req_timer_select] = 16'd0;
                        end else if (mode_ff[req_timer_select][2:1] == 2'd3) begin
                           mode_in[req_timer_select][tcct_pkg::M_SYNC_EN] = 1'b0;
                        end
                     end
                     on_in[req_timer_select] =
                        counting(mode_in[req_timer_select], req_gate_level);
                     exton_in[req_timer_select] =
                        ext_ff[req_timer_select] && on_in[req_timer_select];
                  end
               end
            end
            tcct_pkg::ACT_READ: begin
               if (int'(t) >= TIMER_COUNT) begin
                  rd_in = '1;
               end else begin
                  case (r)
                     tcct_pkg::REG_COUNT:  rd_in = {16'd0, cnt_ff[t]};
                     tcct_pkg::REG_MODE: begin
                        rd_in = {19'd0, mode_ff[t]};
                        mode_in[t][tcct_pkg::M_HIT_TGT] = 1'b0;
                        mode_in[t][tcct_pkg::M_HIT_OVF] = 1'b0;
                     end
                     tcct_pkg::REG_TARGET: rd_in = {16'd0, tgt_ff[t]};
                     default:              rd_in = '1;
                  endcase
               end
            end
            tcct_pkg::ACT_WRITE: begin
               if (int'(t) < TIMER_COUNT) begin
                  case (r)
                     tcct_pkg::REG_COUNT: begin
                        l = check({1'b0, nv}, cnt_ff[t], tgt_ff[t], mode_ff[t],
                                  done_ff[t], 1'b1);
                        cnt_in[t] = l.c; mode_in[t] = l.m; done_in[t] = l.done;
                        irq_in[t] = l.irq;
                        if (l.need_mod) begin
                           mod_pend_in = 1'b1;
                           mod_t_in    = t;
                           mod_rem_in  = 16'd0;
                           mod_quo_in  = nv;
                           mod_n_in    = 5'd0;
                           mod_div_in  = tgt_ff[t];
                        end
                     end
                     tcct_pkg::REG_MODE: begin
                        logic [12:0] m;
                        logic        eu;
                        m  = {mode_ff[t][12:10], req_write_data[9:0]};
                        eu = (t == 2'(PT)) ? m[9] : m[8];
                        ext_in[t] = eu;
                        on_in[t]  = counting(m, gate_ff[t]);
                        exton_in[t] = eu && on_in[t];
                        l = check(17'd0, 16'd0, tgt_ff[t], m, 1'b0, 1'b0);
                        l = irq_step(l);
                        cnt_in[t] = l.c; mode_in[t] = l.m; done_in[t] = l.done;
                        irq_in[t] = l.irq;
                     end
                     tcct_pkg::REG_TARGET: begin
                        tgt_in[t] = nv;
                        l = check({1'b0, cnt_ff[t]}, cnt_ff[t], nv, mode_ff[t],
                                  done_ff[t], 1'b0);
                        cnt_in[t] = l.c; mode_in[t] = l.m; done_in[t] = l.done;
                        irq_in[t] = l.irq;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end

      // One quotient bit per cycle; the remainder is the result.
      if (cmd.mod_step) begin
         mod_pend_in = 1'b1;
         mod_quo_in  = {mod_quo_ff[14:0], 1'b0};
         if (!trial[16]) begin
            mod_rem_in = trial[15:0];
         end else begin
            mod_rem_in = {mod_rem_ff[14:0], mod_quo_ff[15]};
         end
         mod_n_in = mod_n_ff + 5'd1;
         if (mod_n_ff == 5'd15) begin
            mod_pend_in = 1'b0;
            cnt_in[mod_t_ff] = mod_rem_in;
         end
      end else if (mod_pend_ff && !cmd.start) begin
         mod_pend_in = 1'b1;
      end
   end

   assign status.need_mod = mod_pend_ff;
   assign status.mod_done = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            cnt_ff[i]  <= 16'd0;
            tgt_ff[i]  <= 16'd0;
            mode_ff[i] <= tcct_pkg::MODE_RESET;
         end
         gate_ff     <= '0;
         ext_ff      <= '0;
         on_ff       <= '1;
         exton_ff    <= '0;
         done_ff     <= '0;
         pre_ff      <= '0;
         mod_pend_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         tgt_ff      <= tgt_in;
         mode_ff     <= mode_in;
         gate_ff     <= gate_in;
         ext_ff      <= ext_in;
         on_ff       <= on_in;
         exton_ff    <= exton_in;
         done_ff     <= done_in;
         pre_ff      <= pre_in;
         mod_pend_ff <= mod_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff      <= rd_in;
      irq_ff     <= irq_in;
      mod_t_ff   <= mod_t_in;
      mod_rem_ff <= mod_rem_in;
      mod_quo_ff <= mod_quo_in;
      mod_n_ff   <= mod_n_in;
      mod_div_ff <= mod_div_in;
      if (cmd.finish) begin
         rsp_data_ff <= rd_ff;
         rsp_irq_ff  <= irq_ff;
      end
   end

   assign rsp_read_data  = rsp_data_ff;
   assign rsp_irq_raised = rsp_irq_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.mod_step |-> mod_pend_ff)
      else $error("divider step without pending reduction");
   assert property (@(posedge clock) disable iff (reset)
      mod_pend_ff |-> mod_div_ff != 16'd0)
      else $error("reduction by zero target");
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !cmd.mod_step)
      else $error("start and divider step together");

endmodule
